// ----- rtl/ffba_pkg.sv -----
// Shared types and constants of the first-fit block allocator.
// No dependencies; every other file depends on this package.
`default_nettype none
package ffba_pkg;

  localparam int NUM_BLOCKS = 256;
  localparam int ID_BITS    = 32;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int SPAN_W     = 9;
  localparam int CUR_W      = SPAN_W + 1;
  localparam int ADDR_W     = 64;
  localparam int BSIZE_W    = 32;
  localparam int RID_W      = 32;

  localparam logic [ID_BITS-1:0] EMPTY_ID  = {ID_BITS{1'b1}};
  localparam logic [ID_BITS-1:0] LAST_ID   = EMPTY_ID - ID_BITS'(1);

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE_ADDR  = 2'd1,
    OP_FREE_ID    = 2'd2,
    OP_QUERY      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_BAD       = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_START = 3'd4,
    ST_DOUBLE    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_REGION_BASE   = 2'd0,
    CFG_BLOCK_SIZE    = 2'd1,
    CFG_BLOCKS_IN_USE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RUN_RD,
    S_RUN_CHK,
    S_STAMP,
    S_MUL,
    S_ADD,
    S_DIV,
    S_ID_RD,
    S_ID_CHK,
    S_LK_CUR,
    S_LK_PREV,
    S_LK_CHK,
    S_CLEAR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0] owner;
    logic [SPAN_W-1:0]  span;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{owner: EMPTY_ID, span: SPAN_W'(1)};

  // Walk step of an entry: a span of zero advances by one.
  function automatic logic [CUR_W-1:0] step_of(input logic [SPAN_W-1:0] span);
    return (span == '0) ? CUR_W'(1) : {1'b0, span};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ffba_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on ffba_pkg for field widths.
`default_nettype none
interface ffba_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [ffba_pkg::SPAN_W-1:0] block_count;
  logic [ffba_pkg::ADDR_W-1:0] address;
  logic [ffba_pkg::RID_W-1:0]  owner_tag;
  modport source (output valid, operation, block_count, address, owner_tag, input ready);
  modport sink   (input valid, operation, block_count, address, owner_tag, output ready);
endinterface

interface ffba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [ffba_pkg::ADDR_W-1:0] block_address;
  logic [ffba_pkg::RID_W-1:0]  given_id;
  logic [ffba_pkg::SPAN_W-1:0] span_blocks;
  modport source (output valid, status, block_address, given_id, span_blocks, input ready);
  modport sink   (input valid, status, block_address, given_id, span_blocks, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffba_div.sv -----
// Restoring divider, one quotient bit per cycle, for address to block index.
// Depends on ffba_pkg for widths.
`default_nettype none
module ffba_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ffba_pkg::ADDR_W-1:0]  dividend_i,
  input  wire logic [ffba_pkg::BSIZE_W-1:0] divisor_i,
  output logic                              done_o,
  output logic [ffba_pkg::ADDR_W-1:0]       quot_o,
  output logic [ffba_pkg::BSIZE_W-1:0]      rem_o
);
  import ffba_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [ADDR_W-1:0]  quo_q, quo_d;
  logic [BSIZE_W-1:0] rem_q, rem_d;
  logic [BSIZE_W-1:0] dvs_q, dvs_d;
  logic [BSIZE_W:0]   shifted;
  logic [BSIZE_W:0]   diff;

  assign shifted = {rem_q, quo_q[ADDR_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = CNT_W'(ADDR_W);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[BSIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[BSIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

// ----- rtl/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: control FSM, block table memory.
// Depends on ffba_pkg, ffba_if and ffba_div.
//
// Usage: requests arrive on in_i (operation, block_count, address, owner_tag)
// and each produces exactly one response word on out_o (status,
// block_address, given_id, span_blocks). A word moves on a clock edge with
// valid and ready both high. One request is processed at a time; in_i.ready
// is high whenever the control FSM is idle.
// Operation: alloc walks the block table, reading and then checking each
// visited entry, then stamps one entry per cycle and forms the address in
// a multiply step and an add step. Free by address and query run the serial
// divider for the block index (64 quotient bits, then a done flag), then
// read the target entry and its predecessor; free then clears one entry per
// cycle over the region. Free by id walks region starts like alloc. Requests
// rejected on entry go straight to the response state.
// The response register is separate from the FSM: a new request is taken
// while an earlier response waits; a finished one holds in the FSM until
// the output register frees. Reset clears every table entry at once through
// per-entry valid bits, so no clearing pass is needed.
// Configuration writes (region_base, block_size, blocks_in_use) are taken
// any cycle on cfg_we_i and must only occur while the block is idle.
`default_nettype none
module first_fit_block_allocator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [ffba_pkg::ADDR_W-1:0]  cfg_data_i,
  ffba_req_if.sink                          in_i,
  ffba_rsp_if.source                        out_o
);
  import ffba_pkg::*;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_q;
  logic [BSIZE_W-1:0] bsize_q;
  logic [SPAN_W-1:0]  biu_q;

  // Control and working registers.
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [SPAN_W-1:0]  cnt_q, cnt_d;
  logic [RID_W-1:0]   rid_q, rid_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [IDX_W-1:0]   start_q, start_d;
  logic [IDX_W-1:0]   tgt_q, tgt_d;
  logic               in_run_q, in_run_d;
  entry_t             ent_q, ent_d;
  logic [ID_BITS-1:0] next_id_q, next_id_d;
  logic [IDX_W+BSIZE_W-1:0] prod_q, prod_d;

  // Result staging and response register.
  status_e            res_st_q, res_st_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [RID_W-1:0]   res_id_q, res_id_d;
  logic [SPAN_W-1:0]  res_span_q, res_span_d;
  logic               out_v_q, out_v_d;
  status_e            out_st_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [RID_W-1:0]   out_id_q;
  logic [SPAN_W-1:0]  out_span_q;
  logic               out_load;

  // Block table memory and per-entry valid bits.
  entry_t             mem [NUM_BLOCKS];
  entry_t             mem_rd_q;
  logic [NUM_BLOCKS-1:0] ent_v_q;
  logic               rd_v_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic               clr_en;
  entry_t             rd_ent;

  // Divider.
  logic               div_start;
  logic               div_done;
  logic [ADDR_W-1:0]  div_quot;
  logic [BSIZE_W-1:0] div_rem;

  logic [CUR_W-1:0]   n_blocks;
  logic               in_acc;
  logic [CUR_W-1:0]   run_end;
  logic [CUR_W-1:0]   rel_end;
  logic               same_prev;

  assign n_blocks = ({1'b0, biu_q} > CUR_W'(NUM_BLOCKS)) ? CUR_W'(NUM_BLOCKS) : {1'b0, biu_q};
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign rd_ent   = rd_v_q ? mem_rd_q : RESET_ENTRY;
  assign run_end  = CUR_W'(start_q) + CUR_W'(cnt_q);
  assign rel_end  = CUR_W'(tgt_q) + CUR_W'(ent_q.span);
  assign same_prev = (tgt_q != '0) && (rd_ent.owner == ent_q.owner);

  ffba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.address - base_q),
    .divisor_i  (bsize_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    rid_d      = rid_q;
    cur_d      = cur_q;
    start_d    = start_q;
    tgt_d      = tgt_q;
    in_run_d   = in_run_q;
    ent_d      = ent_q;
    next_id_d  = next_id_q;
    prod_d     = prod_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    res_id_d   = res_id_q;
    res_span_d = res_span_q;
    rd_addr    = cur_q[IDX_W-1:0];
    mem_we     = 1'b0;
    wr_addr    = cur_q[IDX_W-1:0];
    wr_data    = '{owner: res_id_q, span: SPAN_W'(run_end - cur_q)};
    clr_en     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = op_e'(in_i.operation);
          cnt_d      = in_i.block_count;
          rid_d      = in_i.owner_tag;
          res_st_d   = ST_OK;
          res_addr_d = '0;
          res_id_d   = '1;
          res_span_d = '0;
          cur_d      = '0;
          in_run_d   = 1'b0;
          unique case (op_e'(in_i.operation))
            OP_ALLOC: begin
              if (in_i.block_count == '0 || next_id_q == LAST_ID) begin
                res_st_d = ST_BAD;
                state_d  = S_RESP;
              end else if (CUR_W'(in_i.block_count) > n_blocks) begin
                res_st_d = ST_NO_SPACE;
                state_d  = S_RESP;
              end else begin
                state_d = S_RUN_RD;
              end
            end
            OP_FREE_ADDR, OP_QUERY: begin
              if (in_i.address == '0 || bsize_q == '0 || in_i.address < base_q) begin
                res_st_d = ST_NOT_FOUND;
                state_d  = S_RESP;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_FREE_ID: begin
              if (ID_BITS'(in_i.owner_tag) >= next_id_q) begin
                res_st_d = ST_NOT_FOUND;
                state_d  = S_RESP;
              end else begin
                state_d = S_ID_RD;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      // Walk for the first free run; cursor reads, data checked next cycle.
      S_RUN_RD: begin
        if (!in_run_q && cur_q >= n_blocks) begin
          res_st_d = ST_NO_SPACE;
          state_d  = S_RESP;
        end else begin
          state_d = S_RUN_CHK;
        end
      end

      S_RUN_CHK: begin
        state_d = S_RUN_RD;
        if (rd_ent.owner == EMPTY_ID) begin
          if (!in_run_q) begin
            if (cur_q + CUR_W'(cnt_q) > n_blocks) begin
              res_st_d = ST_NO_SPACE;
              state_d  = S_RESP;
            end else if (cnt_q == SPAN_W'(1)) begin
              start_d = cur_q[IDX_W-1:0];
              cur_d   = cur_q;
              state_d = S_STAMP;
            end else begin
              start_d  = cur_q[IDX_W-1:0];
              in_run_d = 1'b1;
              cur_d    = cur_q + CUR_W'(1);
            end
          end else if (cur_q + CUR_W'(1) == run_end) begin
            cur_d   = CUR_W'(start_q);
            state_d = S_STAMP;
          end else begin
            cur_d = cur_q + CUR_W'(1);
          end
        end else begin
          in_run_d = 1'b0;
          cur_d    = cur_q + step_of(rd_ent.span);
        end
        if (state_d == S_STAMP) begin
          res_id_d  = RID_W'(next_id_q);
          next_id_d = next_id_q + ID_BITS'(1);
        end
      end

      // Stamp the run one entry per cycle.
      S_STAMP: begin
        mem_we = 1'b1;
        cur_d  = cur_q + CUR_W'(1);
        if (cur_q + CUR_W'(1) == run_end) state_d = S_MUL;
      end

      S_MUL: begin
        prod_d  = start_q * bsize_q;
        state_d = S_ADD;
      end

      S_ADD: begin
        res_addr_d = base_q + ADDR_W'(prod_q);
        state_d    = S_RESP;
      end

      S_DIV: begin
        if (div_done) begin
          if (div_quot >= ADDR_W'(n_blocks)) begin
            res_st_d = ST_NOT_FOUND;
            state_d  = S_RESP;
          end else begin
            tgt_d   = div_quot[IDX_W-1:0];
            state_d = S_LK_CUR;
          end
        end
      end

      // Walk region starts by span for a matching owner.
      S_ID_RD: begin
        if (cur_q >= n_blocks) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_RESP;
        end else begin
          state_d = S_ID_CHK;
        end
      end

      S_ID_CHK: begin
        if (rd_ent.owner == ID_BITS'(rid_q)) begin
          tgt_d   = cur_q[IDX_W-1:0];
          state_d = S_LK_CUR;
        end else begin
          cur_d   = cur_q + step_of(rd_ent.span);
          state_d = S_ID_RD;
        end
      end

      // Read the target entry, then its predecessor.
      S_LK_CUR: begin
        rd_addr = tgt_q;
        state_d = S_LK_PREV;
      end

      S_LK_PREV: begin
        ent_d   = rd_ent;
        rd_addr = tgt_q - IDX_W'(1);
        state_d = S_LK_CHK;
      end

      S_LK_CHK: begin
        state_d = S_RESP;
        if (op_q != OP_FREE_ID && (same_prev || div_rem != '0)) begin
          res_st_d = ST_NOT_FOUND;
        end else if (op_q == OP_QUERY) begin
          res_span_d = ent_q.span;
        end else if (same_prev) begin
          res_st_d = ST_NOT_START;
        end else if (rel_end > n_blocks) begin
          res_st_d = ST_BAD;
        end else if (ent_q.owner == EMPTY_ID) begin
          res_st_d = ST_DOUBLE;
        end else if (ent_q.span != '0) begin
          cur_d   = CUR_W'(tgt_q);
          state_d = S_CLEAR;
        end
      end

      // Drop the region back to reset value one entry per cycle.
      S_CLEAR: begin
        clr_en = 1'b1;
        cur_d  = cur_q + CUR_W'(1);
        if (cur_q + CUR_W'(1) == rel_end) state_d = S_RESP;
      end

      S_RESP: begin
        if (!out_v_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_v_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      next_id_q <= '0;
      out_v_q   <= 1'b0;
      base_q    <= '0;
      bsize_q   <= BSIZE_W'(4096);
      biu_q     <= SPAN_W'(256);
      ent_v_q   <= '0;
      rd_v_q    <= 1'b0;
      in_run_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      out_v_q   <= out_v_d;
      in_run_q  <= in_run_d;
      rd_v_q    <= ent_v_q[rd_addr];
      if (mem_we) ent_v_q[wr_addr] <= 1'b1;
      if (clr_en) ent_v_q[wr_addr] <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REGION_BASE:   base_q  <= cfg_data_i;
          CFG_BLOCK_SIZE:    bsize_q <= cfg_data_i[BSIZE_W-1:0];
          CFG_BLOCKS_IN_USE: biu_q   <= cfg_data_i[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cnt_q      <= cnt_d;
    rid_q      <= rid_d;
    cur_q      <= cur_d;
    start_q    <= start_d;
    tgt_q      <= tgt_d;
    ent_q      <= ent_d;
    prod_q     <= prod_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    res_id_q   <= res_id_d;
    res_span_q <= res_span_d;
    if (out_load) begin
      out_st_q   <= res_st_q;
      out_addr_q <= res_addr_q;
      out_id_q   <= res_id_q;
      out_span_q <= res_span_q;
    end
  end

  // Table memory: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_rd_q <= mem[rd_addr];
  end

  assign out_o.valid         = out_v_q;
  assign out_o.status        = out_st_q;
  assign out_o.block_address = out_addr_q;
  assign out_o.given_id      = out_id_q;
  assign out_o.span_blocks   = out_span_q;

  // The id counter never reaches the empty mark.
  a_id_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_id_q != EMPTY_ID) else $error("id counter reached empty mark");

  // An accepted request always leaves idle.
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE) else $error("request accepted but FSM idle");

  // Stamping and clearing stay inside the managed pool.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STAMP || state_q == S_CLEAR) |-> cur_q < n_blocks)
    else $error("table write outside managed pool");

  // A response is only loaded into a free or draining output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_v_q || out_o.ready)) else $error("response overwritten");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for first_fit_block_allocator: directed words, then random traffic.
// Needs ffba_pkg, the ffba_req_if / ffba_rsp_if interfaces and the allocator RTL.
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] block_address;
    logic [31:0] given_id;
    logic [8:0]  span_blocks;
  } alloc_answer_t;

  // Scoreboard: mirrors the block table and holds answers still owed by the block.
  class alloc_scoreboard;
    logic [31:0]     owner_tbl [NUM_BLOCKS];
    int unsigned     span_tbl [NUM_BLOCKS];
    logic [31:0]     next_id;
    logic [63:0]     region_base;
    logic [31:0]     blk_bytes;
    logic [8:0]      blocks_in_use;
    alloc_answer_t   owed_q[$];
    logic [63:0]     live_addr_q[$];
    logic [31:0]     live_id_q[$];
    int              errors;

    function new();
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        owner_tbl[i] = EMPTY_ID;
        span_tbl[i] = 1;
      end
      next_id = '0;
      region_base = '0;
      blk_bytes = 32'd4096;
      blocks_in_use = 9'd256;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [63:0] data);
      case (idx)
        CFG_REGION_BASE:   region_base = data;
        CFG_BLOCK_SIZE:    blk_bytes = data[31:0];
        CFG_BLOCKS_IN_USE: blocks_in_use = data[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned pool_len();
      return (blocks_in_use < NUM_BLOCKS) ? blocks_in_use : NUM_BLOCKS;
    endfunction

    function int unsigned hop(int unsigned i);
      return (span_tbl[i] == 0) ? 1 : span_tbl[i];
    endfunction

    function bit repeats_prev(int unsigned i);
      return i != 0 && owner_tbl[i-1] == owner_tbl[i];
    endfunction

    function bit first_fit(int unsigned len, output int unsigned at);
      int unsigned n, i, j;
      bit clash;
      n = pool_len();
      i = 0;
      at = 0;
      if (len == 0 || len > n) return 0;
      while (i < n) begin
        if (owner_tbl[i] == EMPTY_ID) begin
          if (i + len > n) return 0;
          clash = 0;
          for (j = 0; j < len; j++)
            if (owner_tbl[i+j] != EMPTY_ID) begin
              clash = 1;
              break;
            end
          if (!clash) begin
            at = i;
            return 1;
          end
          i = i + j + hop(i + j);
        end else begin
          i += hop(i);
        end
      end
      return 0;
    endfunction

    function bit locate_addr(logic [63:0] addr, output int unsigned at);
      logic [63:0] off, idx;
      at = 0;
      if (addr == 0 || blk_bytes == 0 || addr < region_base) return 0;
      off = addr - region_base;
      idx = off / {32'd0, blk_bytes};
      if (idx >= pool_len()) return 0;
      if (repeats_prev(32'(idx))) return 0;
      if (off % {32'd0, blk_bytes} != 0) return 0;
      at = 32'(idx);
      return 1;
    endfunction

    function bit locate_id(logic [31:0] id, output int unsigned at);
      int unsigned n;
      n = pool_len();
      at = 0;
      if (id >= next_id) return 0;
      for (int unsigned i = 0; i < n; i += hop(i))
        if (owner_tbl[i] == id) begin
          at = i;
          return 1;
        end
      return 0;
    endfunction

    function status_e clear_region(bit found, int unsigned i);
      int unsigned s;
      if (!found) return ST_NOT_FOUND;
      if (repeats_prev(i)) return ST_NOT_START;
      s = span_tbl[i];
      if (i + s > pool_len()) return ST_BAD;
      if (owner_tbl[i] == EMPTY_ID) return ST_DOUBLE;
      for (int unsigned j = i; j < i + s; j++) begin
        owner_tbl[j] = EMPTY_ID;
        span_tbl[j] = 1;
      end
      return ST_OK;
    endfunction

    // Note an accepted request word: update the mirror and owe its answer.
    function void note_request(op_e op, logic [8:0] count, logic [63:0] addr,
                               logic [31:0] rid);
      alloc_answer_t a;
      int unsigned i;
      bit found;
      a.status = ST_OK;
      a.block_address = '0;
      a.given_id = '1;
      a.span_blocks = '0;
      case (op)
        OP_ALLOC: begin
          if (count == 0 || next_id == LAST_ID) a.status = ST_BAD;
          else if (!first_fit(count, i)) a.status = ST_NO_SPACE;
          else begin
            for (int unsigned k = 0; k < count; k++) begin
              owner_tbl[i+k] = next_id;
              span_tbl[i+k] = count - k;
            end
            a.block_address = region_base + 64'(i) * {32'd0, blk_bytes};
            a.given_id = next_id;
            next_id = next_id + 1;
            live_addr_q.push_back(a.block_address);
            live_id_q.push_back(a.given_id);
            if (live_addr_q.size() > 48) begin
              void'(live_addr_q.pop_front());
              void'(live_id_q.pop_front());
            end
          end
        end
        OP_FREE_ADDR: begin
          found = locate_addr(addr, i);
          a.status = clear_region(found, i);
        end
        OP_FREE_ID: begin
          found = locate_id(rid, i);
          a.status = clear_region(found, i);
        end
        default: begin
          if (locate_addr(addr, i)) a.span_blocks = span_tbl[i][8:0];
          else a.status = ST_NOT_FOUND;
        end
      endcase
      owed_q.push_back(a);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    task check_answer(alloc_answer_t got);
      alloc_answer_t want;
      if (owed_q.size() == 0) begin
        report("unexpected response word", 64'(got.status), 64'(0));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
      if (got.block_address !== want.block_address)
        report("block_address", got.block_address, want.block_address);
      if (got.given_id !== want.given_id) report("given_id", 64'(got.given_id), 64'(want.given_id));
      if (got.span_blocks !== want.span_blocks)
        report("span_blocks", 64'(got.span_blocks), 64'(want.span_blocks));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  ffba_req_if req_if ();
  ffba_rsp_if rsp_if ();

  first_fit_block_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if.sink),
    .out_o      (rsp_if.source)
  );

  alloc_scoreboard sb = new();
  int hold_off_cycles = 0;   // a long receiver stall requested by the stimulus

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Send one request word. Valid stays high between back-to-back words.
  task send_word(op_e op, logic [8:0] count, logic [63:0] addr, logic [31:0] rid);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.block_count <= count;
    req_if.address     <= addr;
    req_if.owner_tag   <= rid;
    // Outputs change only through nonblocking updates, so ready read here is
    // the value seen by the edge itself.
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(op, count, addr, rid);
  endtask

  // Drop valid and hold until every owed answer has come back.
  task drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One write; cfg_we_i is dropped again before the task returns, so back-to-back writes never collide.
  task write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task set_pool(logic [63:0] base, logic [31:0] bsize, logic [8:0] nblk);
    drain();
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_BLOCK_SIZE, {32'd0, bsize});
    write_reg(CFG_BLOCKS_IN_USE, {55'd0, nblk});
    @(posedge clk_i);
  endtask

  // Pick an address: half the time a live region start, otherwise block-aligned,
  // off-boundary, or fully random.
  function logic [63:0] pick_addr();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && sb.live_addr_q.size() != 0)
      return sb.live_addr_q[$urandom_range(0, sb.live_addr_q.size() - 1)];
    if (sel < 8)
      return sb.region_base + 64'($urandom_range(0, sb.pool_len())) * {32'd0, sb.blk_bytes}
             + ((sel == 7) ? 64'd1 : 64'd0);
    return {$urandom, $urandom};
  endfunction

  function logic [31:0] pick_id();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && sb.live_id_q.size() != 0)
      return sb.live_id_q[$urandom_range(0, sb.live_id_q.size() - 1)];
    if (sel < 9) return sb.next_id - $urandom_range(0, 4);
    return $urandom;
  endfunction

  function logic [8:0] pick_count();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 9'd0;
    if (sel < 16) return 9'($urandom_range(1, 8));
    return 9'($urandom_range(1, 256));
  endfunction

  // Random phase: alloc-heavy with well-formed frees of live regions, plus noise.
  task random_words(int n);
    int sel;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)      send_word(OP_ALLOC, pick_count(), {$urandom, $urandom}, $urandom);
      else if (sel < 6) send_word(OP_FREE_ADDR, 9'($urandom), pick_addr(), $urandom);
      else if (sel < 8) send_word(OP_FREE_ID, 9'($urandom), {$urandom, $urandom}, pick_id());
      else              send_word(OP_QUERY, 9'($urandom), pick_addr(), $urandom);
    end
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  initial begin
    int stall;
    alloc_answer_t got;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (hold_off_cycles != 0) ? hold_off_cycles
            : ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      hold_off_cycles = 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      got.status        = rsp_if.status;
      got.block_address = rsp_if.block_address;
      got.given_id      = rsp_if.given_id;
      got.span_blocks   = rsp_if.span_blocks;
      sb.check_answer(got);
    end
  end

  initial begin
    logic [63:0] b;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = '0;
    req_if.block_count = '0;
    req_if.address     = '0;
    req_if.owner_tag   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default pool, a region straddling a later pool cut.
    send_word(OP_ALLOC, 9'd2, '0, '0);             // id 0 at block 0
    send_word(OP_ALLOC, 9'd8, '0, '0);             // id 1 at block 2
    send_word(OP_ALLOC, 9'd0, '0, '0);             // zero count rejected
    send_word(OP_ALLOC, 9'd256, '0, '0);           // no run that long
    send_word(OP_QUERY, '0, 64'd8192, '0);         // span 8
    send_word(OP_QUERY, '0, 64'd12288, '0);        // inside a region: not found
    send_word(OP_FREE_ADDR, '0, 64'd12288, '0);    // not found as well
    send_word(OP_QUERY, '0, 64'd0, '0);            // address zero
    send_word(OP_QUERY, '0, 64'd8193, '0);         // off boundary
    send_word(OP_FREE_ADDR, '0, '1, '0);           // beyond the pool
    drain();
    write_reg(CFG_BLOCKS_IN_USE, 64'd4);
    send_word(OP_FREE_ADDR, '0, 64'd8192, '0);     // span runs past the pool
    send_word(OP_FREE_ID, '0, '0, 32'd1);          // same region found by id
    drain();
    write_reg(CFG_BLOCKS_IN_USE, 64'd256);
    send_word(OP_FREE_ID, '0, '0, 32'd1);          // ok
    send_word(OP_FREE_ID, '0, '0, 32'd1);          // gone: not found
    send_word(OP_FREE_ID, '0, '0, '1);             // id never given
    send_word(OP_FREE_ADDR, '0, 64'd8192, '0);     // empty block: double free
    send_word(OP_FREE_ADDR, '0, 64'd4096, '0);     // second block of id 0: not found
    send_word(OP_FREE_ADDR, '0, 64'd0, '0);
    send_word(OP_FREE_ADDR, '0, 64'd8192, '0);
    send_word(OP_ALLOC, 9'd256, '0, '0);           // id 0 still in the way
    send_word(OP_QUERY, '0, '0, '0);
    drain();
    // Block 0 still holds id 0; move the pool so block 0 sits at 0x40,
    // free it, then free the now empty block again.
    set_pool(64'h40, 32'h40, 9'd256);
    send_word(OP_FREE_ADDR, '0, 64'h40, '0);
    send_word(OP_FREE_ADDR, '0, 64'h40, '0);       // empty block 0: double free
    send_word(OP_QUERY, '0, 64'h3F, '0);           // below base

    random_words(120);

    // Pressure: long receiver stall while words keep coming, then a pause.
    hold_off_cycles = 400;
    random_words(20);
    drain();

    set_pool(64'h1000_0000_0000_0000, 32'd1, 9'd16);
    random_words(80);
    set_pool(64'hFFFF_FFFF_FFFF_0000, 32'h100, 9'd256);   // addresses wrap
    random_words(80);
    b = {$urandom, $urandom};
    set_pool(b & ~64'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd1);
    random_words(30);
    set_pool(64'd0, 32'd4096, 9'd256);
    random_words(100);

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
